@@ sv/stereo_feedback_delay_core_assert.svh @@
// Assertion macros for the stereo feedback delay core.
`ifndef STEREO_FEEDBACK_DELAY_CORE_ASSERT_SVH
`define STEREO_FEEDBACK_DELAY_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Property checked while out of reset.
`define SFD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sfd assertion failed");

// Property checked at every edge, reset included.
`define SFD_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("sfd assertion failed");

`else

`define SFD_ASSERT(lbl, prop)
`define SFD_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

@@ sv/sfd_pkg.sv @@
// Shared constants, types and arithmetic helpers for the stereo feedback delay.
`timescale 1ns / 1ps

package sfd_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 16;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [32:0]            acc_t;

    // Register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_DELAY_LENGTH  = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FEEDBACK_GAIN = 4'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WET_GAIN      = 4'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DRY_GAIN      = 4'd3;

    // Gain limits and reset values (gains in Q1.15, delay length in frames)
    localparam logic [14:0] FB_MAX      = 15'd32440;
    localparam logic [15:0] GAIN_ONE    = 16'd32768;
    localparam logic [15:0] DELAY_RESET = 16'd12000;
    localparam logic [14:0] FB_RESET    = 15'd0;
    localparam logic [15:0] WET_RESET   = 16'd16384;
    localparam logic [15:0] DRY_RESET   = 16'd32768;

    localparam acc_t ROUND_HALF = 33'sd16384;

    // Round half up, drop 15 fraction bits, clamp to the sample range
    function automatic sample_t round_sat(input acc_t acc);
        acc_t                r;
        logic signed [17:0]  q;
        sample_t             res;
        r = acc + ROUND_HALF;
        q = r[32:15];
        if (q > 18'sd32767)
            res = 16'sh7FFF;
        else if (q < -18'sd32768)
            res = 16'sh8000;
        else
            res = q[15:0];
        return res;
    endfunction

endpackage

@@ sv/sfd_ram.sv @@
// Generic single-clock RAM, one write port and one registered read port (read-first).
`timescale 1ns / 1ps

module sfd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read returns old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ sv/stereo_feedback_delay_core.sv @@
// Top level of the stereo feedback delay: config, sample memory pipeline, output queue.
//
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+----------------------------
//  in      | in        | in_valid/in_stall   | left_in, right_in
//  out     | out       | out_valid/out_stall | left_out, right_out
//  cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One stereo word per clock while in_stall is low; the limit is the single
// read-modify-write of the sample memory per frame, with the feedback loop closed
// through the write-back bypass. An accepted word passes stage 1 and stage 2 into the queue.
// After reset the whole memory is swept to zero, with in_stall high.
// A four-word output queue keeps the pipeline flowing while out_stall is high;
// in_stall rises once the queue plus words in flight would fill it.
`timescale 1ns / 1ps

module stereo_feedback_delay_core #(
    parameter int FRAME_DEPTH = 65536
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [15:0]                   left_in,
    input  logic signed [15:0]                   right_in,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [15:0]                   left_out,
    output logic signed [15:0]                   right_out,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sfd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [sfd_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

`include "stereo_feedback_delay_core_assert.svh"

    localparam int AW = $clog2(FRAME_DEPTH);
    localparam int SW = ((AW > 16) ? AW : 16) + 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(FRAME_DEPTH - 1);
    localparam logic [15:0] DLY_RST =
        (32'(sfd_pkg::DELAY_RESET) > 32'(FRAME_DEPTH - 1)) ? 16'(FRAME_DEPTH - 1)
                                                           : sfd_pkg::DELAY_RESET;
    localparam int FIFO_DEPTH = 4;
    localparam int FPW = $clog2(FIFO_DEPTH);
    localparam int FCW = FPW + 1;

    // ------------------------------------------------------------------
    // Configuration registers, stored already clamped
    // ------------------------------------------------------------------
    logic [15:0] dly_reg;
    logic [14:0] fb_reg;
    logic [15:0] wet_reg;
    logic [15:0] dry_reg;
    logic [15:0] dly_wr;
    logic [14:0] fb_wr;
    logic [15:0] gain_wr;
    logic        cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_comb
    begin
        if (cfg_data == 16'd0)
            dly_wr = 16'd1;
        else if (32'(cfg_data) > 32'(FRAME_DEPTH - 1))
            dly_wr = 16'(FRAME_DEPTH - 1);
        else
            dly_wr = cfg_data;

        fb_wr   = (cfg_data[14:0] > sfd_pkg::FB_MAX) ? sfd_pkg::FB_MAX : cfg_data[14:0];
        gain_wr = (cfg_data > sfd_pkg::GAIN_ONE) ? sfd_pkg::GAIN_ONE : cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dly_reg <= DLY_RST;
            fb_reg  <= sfd_pkg::FB_RESET;
            wet_reg <= sfd_pkg::WET_RESET;
            dry_reg <= sfd_pkg::DRY_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sfd_pkg::REG_DELAY_LENGTH:  dly_reg <= dly_wr;
                sfd_pkg::REG_FEEDBACK_GAIN: fb_reg  <= fb_wr;
                sfd_pkg::REG_WET_GAIN:      wet_reg <= gain_wr;
                sfd_pkg::REG_DRY_GAIN:      dry_reg <= gain_wr;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Clearing sweep and write position
    // ------------------------------------------------------------------
    logic          clearing_reg;
    logic [AW-1:0] clr_addr_reg;
    logic [AW-1:0] wp_reg;
    logic          in_acc;

    assign in_acc = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
            wp_reg       <= '0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_ADDR)
                    clearing_reg <= 1'b0;
            end
            if (in_acc)
                wp_reg <= (wp_reg == LAST_ADDR) ? '0 : wp_reg + 1'b1;
        end
    end

    // Read position: write position minus delay, modulo depth
    logic [SW-1:0] rp_diff;
    logic [AW-1:0] rp;

    always_comb
    begin
        rp_diff = SW'(wp_reg) - SW'(dly_reg);
        if (rp_diff[SW-1])
            rp = AW'(rp_diff + SW'(FRAME_DEPTH));
        else
            rp = AW'(rp_diff);
    end

    // ------------------------------------------------------------------
    // Stage 1: memory data, forwarding, feedback store, output products
    // ------------------------------------------------------------------
    logic                v1_reg;
    logic [AW-1:0]       wp1_reg;
    logic [AW-1:0]       rp1_reg;
    sfd_pkg::sample_t    inl1_reg;
    sfd_pkg::sample_t    inr1_reg;

    logic                wb_valid_reg;
    logic [AW-1:0]       wb_addr_reg;
    logic [31:0]         wb_data_reg;

    logic [31:0]         ram_rd;
    logic [31:0]         dly_frame;
    sfd_pkg::sample_t    dl;
    sfd_pkg::sample_t    dr;
    sfd_pkg::acc_t       acc_fb_l;
    sfd_pkg::acc_t       acc_fb_r;
    sfd_pkg::sample_t    st_l;
    sfd_pkg::sample_t    st_r;
    logic [31:0]         st_frame;

    logic signed [15:0]  fb_s;
    logic signed [16:0]  wet_s;
    logic signed [16:0]  dry_s;
    sfd_pkg::acc_t       pdl;
    sfd_pkg::acc_t       pwl;
    sfd_pkg::acc_t       pdr;
    sfd_pkg::acc_t       pwr;

    logic                ram_we;
    logic [AW-1:0]       ram_wa;
    logic [31:0]         ram_wd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            wb_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_acc;
            if (v1_reg)
                wb_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            wp1_reg  <= wp_reg;
            rp1_reg  <= rp;
            inl1_reg <= left_in;
            inr1_reg <= right_in;
        end
        if (v1_reg)
        begin
            wb_addr_reg <= wp1_reg;
            wb_data_reg <= st_frame;
        end
    end

    // Last write is not yet visible in the read data: take it from the bypass
    assign dly_frame = (wb_valid_reg && (wb_addr_reg == rp1_reg)) ? wb_data_reg : ram_rd;
    assign dl = dly_frame[31:16];
    assign dr = dly_frame[15:0];

    assign fb_s  = $signed({1'b0, fb_reg});
    assign wet_s = $signed({1'b0, wet_reg});
    assign dry_s = $signed({1'b0, dry_reg});

    // Stored frame: input plus feedback-scaled delayed frame
    always_comb
    begin
        acc_fb_l = $signed({inl1_reg[15], inl1_reg[15], inl1_reg, 15'd0}) + dl * fb_s;
        acc_fb_r = $signed({inr1_reg[15], inr1_reg[15], inr1_reg, 15'd0}) + dr * fb_s;
    end

    assign st_l     = sfd_pkg::round_sat(acc_fb_l);
    assign st_r     = sfd_pkg::round_sat(acc_fb_r);
    assign st_frame = {st_l, st_r};

    // Output mix products
    assign pdl = 33'(inl1_reg) * 33'(dry_s);
    assign pwl = 33'(dl) * 33'(wet_s);
    assign pdr = 33'(inr1_reg) * 33'(dry_s);
    assign pwr = 33'(dr) * 33'(wet_s);

    // Memory write port: clearing sweep, then item write-back
    always_comb
    begin
        if (clearing_reg)
        begin
            ram_we = 1'b1;
            ram_wa = clr_addr_reg;
            ram_wd = '0;
        end
        else
        begin
            ram_we = v1_reg;
            ram_wa = wp1_reg;
            ram_wd = st_frame;
        end
    end

    sfd_ram #(
        .WIDTH (32),
        .DEPTH (FRAME_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_wa),
        .wr_data (ram_wd),
        .rd_addr (rp),
        .rd_data (ram_rd)
    );

    // ------------------------------------------------------------------
    // Stage 2: mix sums, round, saturate, push into the output queue
    // ------------------------------------------------------------------
    logic             v2_reg;
    sfd_pkg::acc_t    pdl2_reg;
    sfd_pkg::acc_t    pwl2_reg;
    sfd_pkg::acc_t    pdr2_reg;
    sfd_pkg::acc_t    pwr2_reg;
    sfd_pkg::sample_t mix_l;
    sfd_pkg::sample_t mix_r;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            pdl2_reg <= pdl;
            pwl2_reg <= pwl;
            pdr2_reg <= pdr;
            pwr2_reg <= pwr;
        end
    end

    assign mix_l = sfd_pkg::round_sat(pdl2_reg + pwl2_reg);
    assign mix_r = sfd_pkg::round_sat(pdr2_reg + pwr2_reg);

    // ------------------------------------------------------------------
    // Output queue
    // ------------------------------------------------------------------
    sfd_pkg::sample_t fifo_l [FIFO_DEPTH];
    sfd_pkg::sample_t fifo_r [FIFO_DEPTH];
    logic [FPW-1:0]   wr_ptr_reg;
    logic [FPW-1:0]   rd_ptr_reg;
    logic [FCW-1:0]   cnt_reg;
    logic [FCW-1:0]   cnt_next;
    logic [FCW-1:0]   committed;
    logic             pop;

    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign left_out  = fifo_l[rd_ptr_reg];
    assign right_out = fifo_r[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (v2_reg && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (!v2_reg && pop)
            cnt_next = cnt_reg - 1'b1;
    end

    // Credit: queue entries plus words still in the pipeline
    assign committed = cnt_reg + FCW'(v1_reg) + FCW'(v2_reg);
    assign in_stall  = clearing_reg || (committed >= FCW'(FIFO_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (v2_reg)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v2_reg)
        begin
            fifo_l[wr_ptr_reg] <= mix_l;
            fifo_r[wr_ptr_reg] <= mix_r;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `SFD_ASSERT(a_credit_bound, committed <= FCW'(FIFO_DEPTH))
    `SFD_ASSERT(a_no_item_while_clearing, clearing_reg |-> (!v1_reg && !v2_reg && cnt_reg == '0))
    `SFD_ASSERT(a_wp_zero_after_clear, $fell(clearing_reg) |-> (wp_reg == '0))
    `SFD_ASSERT_ALWAYS(a_bypass_needs_write, wb_valid_reg |-> !clearing_reg)

endmodule
